// ----- rtl/core/gyrohp_pkg.sv -----
package gyrohp_pkg;

  // field widths
  localparam int TIME_W   = 48;
  localparam int RATE_W   = 32;
  localparam int ANGLE_W  = 48;
  localparam int ALPHA_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_AXES   = 3;

  // tick difference is multiplied in two halves
  localparam int DT_SPLIT = 24;
  localparam int DT_HI_W  = TIME_W - DT_SPLIT;
  localparam int PLO_W    = RATE_W + DT_SPLIT;
  localparam int PHI_W    = RATE_W + DT_HI_W;
  localparam int PROD_W   = RATE_W + TIME_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = CFG_IDX_W'(1);

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = {ALPHA_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0]         sample_time;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_theta;
    logic                      start_of_run;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0]         out_time;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_theta;
    logic                      saturated;
  } out_word_t;

  // filter stage control, shared by the three axis lanes
  typedef struct packed {
    logic               load;
    logic               seed;
    logic               bypass;
    logic [ALPHA_W-1:0] alpha;
  } front_ctl_t;

  // accumulate stage control
  typedef struct packed {
    logic load;
    logic seed;
  } accum_ctl_t;

endpackage

// ----- rtl/core/gyro_highpass_integrator_unit.sv -----
// Three-axis gyro high-pass filter and angle integrator. Takes one word per
// clock while in_stall is low and gives one result word per input word, in
// order. The first stage registers the input, the second runs the three
// first-order high-pass filters and the rate-times-ticks partial products,
// the third adds them into the saturating angle accumulators and holds the
// result until it is taken. The filter feedback and the accumulator add each
// close through a single register, so the sustained rate is one word per
// cycle while out_stall is low; in_stall rises only when all three stages are
// full and out_stall is high. A word with start_of_run set, or the first word
// after reset, seeds the filters and gives zero angles with saturated clear.
// Registers: 0 alpha (unsigned Q0.16, reset all ones), 1 filter bypass.
// Writes to other indexes are ignored; cfg_ready is always high.
module gyro_highpass_integrator_unit
  import gyrohp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ALPHA_W-1:0] alpha;
  logic               bypass;

  logic               v0;
  logic               v1;
  logic               en0;
  logic               en1;
  logic               en2;
  logic               ld1;
  logic               ld2;

  in_word_t           in_q;
  logic [TIME_W-1:0]  prev_time;
  logic               run_started;
  logic               seed0;
  logic [TIME_W-1:0]  dt;

  logic [TIME_W-1:0]  t1;
  logic               seed1;
  logic [TIME_W-1:0]  t2;
  logic               sticky;

  front_ctl_t         front_ctl;
  accum_ctl_t         accum_ctl;

  logic [RATE_W-1:0]  lane_rate [NUM_AXES];
  logic [ANGLE_W-1:0] lane_angle [NUM_AXES];
  logic [NUM_AXES-1:0] lane_filt_sat;
  logic [NUM_AXES-1:0] lane_acc_sat;
  logic [NUM_AXES-1:0] lane_neg;
  logic [PLO_W-1:0]   lane_lo [NUM_AXES];
  logic [PHI_W-1:0]   lane_hi [NUM_AXES];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= ALPHA_RESET;
      bypass <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA:  alpha  <= cfg_data[ALPHA_W-1:0];
        CFG_BYPASS: bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advance: a stage moves when the one after it is free or moving
  assign en2      = !out_valid || !out_stall;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_stall = !en0;
  assign ld1      = en1 && v0;
  assign ld2      = en2 && v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= in_valid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        out_valid <= v1;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en0) begin
      in_q <= in_word;
    end
  end

  // run tracking and tick difference, modulo 2^48
  assign seed0 = in_q.start_of_run || !run_started;
  assign dt    = in_q.sample_time - prev_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_started <= 1'b0;
    end else if (ld1) begin
      run_started <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      prev_time <= in_q.sample_time;
      t1        <= in_q.sample_time;
      seed1     <= seed0;
    end
  end

  // filter stage lanes
  assign front_ctl = '{load: ld1, seed: seed0, bypass: bypass, alpha: alpha};
  assign lane_rate[0] = in_q.rate_x;
  assign lane_rate[1] = in_q.rate_y;
  assign lane_rate[2] = in_q.rate_theta;

  // accumulate stage lanes
  assign accum_ctl = '{load: ld2, seed: seed1};

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    gyrohp_front u_front (
      .clk      (clk),
      .ctl      (front_ctl),
      .dt       (dt),
      .rate     (lane_rate[i]),
      .filt_sat (lane_filt_sat[i]),
      .prod_neg (lane_neg[i]),
      .prod_lo  (lane_lo[i]),
      .prod_hi  (lane_hi[i])
    );

    gyrohp_accum u_accum (
      .clk      (clk),
      .ctl      (accum_ctl),
      .prod_neg (lane_neg[i]),
      .prod_lo  (lane_lo[i]),
      .prod_hi  (lane_hi[i]),
      .angle    (lane_angle[i]),
      .acc_sat  (lane_acc_sat[i])
    );
  end

  // result register and sticky saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sticky <= 1'b0;
    end else if (ld2) begin
      sticky <= seed1 ? 1'b0 : (sticky || (|lane_filt_sat) || (|lane_acc_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      t2 <= t1;
    end
  end

  assign out_word = '{out_time:    t2,
                      angle_x:     lane_angle[0],
                      angle_y:     lane_angle[1],
                      angle_theta: lane_angle[2],
                      saturated:   sticky};

endmodule

// ----- rtl/core/gyrohp_front.sv -----
module gyrohp_front
  import gyrohp_pkg::*;
(
  input  logic              clk,
  input  front_ctl_t        ctl,
  input  logic [TIME_W-1:0] dt,
  input  logic [RATE_W-1:0] rate,
  output logic              filt_sat,
  output logic              prod_neg,
  output logic [PLO_W-1:0]  prod_lo,
  output logic [PHI_W-1:0]  prod_hi
);

  localparam int SUM_W = RATE_W + 2;
  localparam int SCL_W = RATE_W + ALPHA_W + 2;

  localparam logic [SUM_W-1:0]  Q_POS_MAX  = {3'b000, {(RATE_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  Q_NEG_MAX  = {3'b001, {(RATE_W-1){1'b0}}};
  localparam logic [RATE_W-1:0] RATE_MAX   = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_MIN   = {1'b1, {(RATE_W-1){1'b0}}};
  localparam logic [SCL_W-1:0]  ROUND_HALF = SCL_W'(1) << (FRAC_W - 1);

  logic [RATE_W-1:0] prev_raw;
  logic [RATE_W-1:0] prev_filt;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  smag;
  logic [SCL_W-1:0]  scaled;
  logic [SUM_W-1:0]  q;
  logic              sum_neg;
  logic              clip_hit;
  logic [RATE_W-1:0] filt_val;
  logic [RATE_W-1:0] filt_next;
  logic [RATE_W-1:0] mag;

  // high-pass: alpha * (y_prev + x - x_prev), rounded on the magnitude
  always_comb begin
    sum = {{2{prev_filt[RATE_W-1]}}, prev_filt} + {{2{rate[RATE_W-1]}}, rate}
        - {{2{prev_raw[RATE_W-1]}}, prev_raw};
    sum_neg = sum[SUM_W-1];
    smag    = sum_neg ? (~sum + SUM_W'(1)) : sum;
    scaled  = SCL_W'(smag) * SCL_W'(ctl.alpha) + ROUND_HALF;
    q       = scaled[SCL_W-1:FRAC_W];
    if (sum_neg) begin
      clip_hit = (q > Q_NEG_MAX);
      filt_val = clip_hit ? RATE_MIN : (~q[RATE_W-1:0] + RATE_W'(1));
    end else begin
      clip_hit = (q > Q_POS_MAX);
      filt_val = clip_hit ? RATE_MAX : q[RATE_W-1:0];
    end
    filt_next = (ctl.seed || ctl.bypass) ? rate : filt_val;
  end

  // magnitude of the rate that drives this step's integration
  assign mag = prev_filt[RATE_W-1] ? (~prev_filt + RATE_W'(1)) : prev_filt;

  // filter history and partial products for the accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prev_raw  <= rate;
      prev_filt <= filt_next;
      filt_sat  <= !ctl.seed && !ctl.bypass && clip_hit;
      prod_neg  <= prev_filt[RATE_W-1];
      prod_lo   <= PLO_W'(mag) * PLO_W'(dt[DT_SPLIT-1:0]);
      prod_hi   <= PHI_W'(mag) * PHI_W'(dt[TIME_W-1:DT_SPLIT]);
    end
  end

endmodule

// ----- rtl/core/gyrohp_accum.sv -----
module gyrohp_accum
  import gyrohp_pkg::*;
(
  input  logic               clk,
  input  accum_ctl_t         ctl,
  input  logic               prod_neg,
  input  logic [PLO_W-1:0]   prod_lo,
  input  logic [PHI_W-1:0]   prod_hi,
  output logic [ANGLE_W-1:0] angle,
  output logic               acc_sat
);

  localparam int ACC_W = ANGLE_W + 2;

  localparam logic [PROD_W-1:0]  LIM_POS   = PROD_W'({1'b0, {(ANGLE_W-1){1'b1}}});
  localparam logic [PROD_W-1:0]  LIM_NEG   = PROD_W'({1'b1, {(ANGLE_W-1){1'b0}}});
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  lim;
  logic               prod_over;
  logic [PROD_W-1:0]  p;
  logic [ACC_W-1:0]   p_ext;
  logic [ACC_W-1:0]   term;
  logic [ACC_W-1:0]   sum;
  logic               sum_ok;
  logic [ANGLE_W-1:0] angle_next;

  // full product, clipped to the angle range
  always_comb begin
    prod      = PROD_W'(prod_lo) + (PROD_W'(prod_hi) << DT_SPLIT);
    lim       = prod_neg ? LIM_NEG : LIM_POS;
    prod_over = (prod > lim);
    p         = prod_over ? lim : prod;
    p_ext     = ACC_W'(p[ANGLE_W-1:0]);
    term      = prod_neg ? (~p_ext + ACC_W'(1)) : p_ext;
  end

  // saturating add into the angle
  always_comb begin
    sum    = {{2{angle[ANGLE_W-1]}}, angle} + term;
    sum_ok = (sum[ACC_W-1:ANGLE_W-1] == 3'b000) || (sum[ACC_W-1:ANGLE_W-1] == 3'b111);
    if (sum_ok) begin
      angle_next = sum[ANGLE_W-1:0];
    end else if (sum[ACC_W-1]) begin
      angle_next = ANGLE_MIN;
    end else begin
      angle_next = ANGLE_MAX;
    end
    acc_sat = prod_over || !sum_ok;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      angle <= ctl.seed ? '0 : angle_next;
    end
  end

endmodule

// ----- rtl/core/gyrohp_checker.sv -----
module gyrohp_checker
  import gyrohp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled input word stays and holds its value
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  // a stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // the input side only backs up when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output can drain");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind gyro_highpass_integrator_unit gyrohp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
